/* sv/uft_pkg.sv */
// Shared phase codes, register indexes and beat layouts for the UART frame transceiver.
package uft_pkg;

    // Transmit phase codes
    localparam logic [2:0] TXP_IDLE   = 3'd0;
    localparam logic [2:0] TXP_START  = 3'd1;
    localparam logic [2:0] TXP_DATA   = 3'd2;
    localparam logic [2:0] TXP_PARITY = 3'd3;
    localparam logic [2:0] TXP_STOP   = 3'd4;
    localparam logic [2:0] TXP_GUARD  = 3'd5;

    // Receive phase codes
    localparam logic [2:0] RXP_IDLE   = 3'd0;
    localparam logic [2:0] RXP_DATA   = 3'd1;
    localparam logic [2:0] RXP_PARITY = 3'd2;
    localparam logic [2:0] RXP_STOP   = 3'd3;
    localparam logic [2:0] RXP_GUARD  = 3'd4;

    // Configuration register indexes
    localparam logic CFG_DATA_BITS  = 1'b0;
    localparam logic CFG_PARITY_EN  = 1'b1;

    // Item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // Frame length limits
    localparam logic [3:0] DATA_BITS_MIN = 4'd5;
    localparam logic [3:0] DATA_BITS_MAX = 4'd8;

    // Beat widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // One result beat, before packing
    typedef struct packed {
        logic       parity_error;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       load_dropped;
        logic       tx_busy;
        logic       tx_level;
    } t_result;

endpackage

/* sv/uart_frame_transceiver_top.sv */
// UART frame transceiver: one tick or load beat in, one status beat out per cycle while the m side accepts.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+-------------------------------------------
//  s       | in  | i_s_tvalid / o_s_tready    | tuser: kind; tdata: tx_byte, rx_level
//  m       | out | o_m_tvalid / i_m_tready    | tdata: tx_level .. parity_error
//  cfg     | in  | i_cfg_we (no wait)         | i_cfg_addr, i_cfg_wdata
//
// An accepted beat is held in the input register, then both serial state machines advance
// and the result is registered; one beat per cycle is sustained while the m side accepts.
// Synchronous active-low reset returns both sides to idle with the line high.
// A stall on the m side holds the result register; o_s_tready drops as soon as the input
// register also holds a beat, in the same cycle as the stall when beats run back to back.
module uart_frame_transceiver_top
    import uft_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [7:0] tx_byte, [8] rx_level, rest zero
    input  logic                   i_s_tuser,   // [0] kind
    // output stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [0] tx_level, [1] tx_busy,
                                                // [2] load_dropped, [3] rx_valid,
                                                // [11:4] rx_byte, [12] parity_error
    // configuration writes
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_addr,
    input  logic [3:0]             i_cfg_wdata
);

    // configuration registers
    logic [3:0] r_cfg_bits;
    logic       r_cfg_par;

    // input register
    logic       r_in_valid;
    logic       r_in_kind;
    logic [7:0] r_in_byte;
    logic       r_in_level;

    // output register
    logic       r_out_valid;
    t_result    r_out;

    // frame state
    logic [2:0] r_tx_phase, n_tx_phase;
    logic [7:0] r_tx_shift, n_tx_shift;
    logic [3:0] r_tx_cnt,   n_tx_cnt;
    logic       r_tx_par,   n_tx_par;
    logic       r_tx_line,  n_tx_line;
    logic [2:0] r_rx_phase, n_rx_phase;
    logic [7:0] r_rx_shift, n_rx_shift;
    logic [3:0] r_rx_cnt,   n_rx_cnt;
    logic       r_rx_par,   n_rx_par;
    logic       r_rx_flag,  n_rx_flag;

    t_result    n_out;
    logic [3:0] frame_bits;
    logic [3:0] tx_cnt_inc, rx_cnt_inc;
    logic       tx_bit;
    logic       out_free, work_go;
    logic       load_drop;
    logic       rx_done;
    logic [7:0] rx_data;
    logic       rx_perr;

    // handshake
    assign out_free   = !r_out_valid || i_m_tready;
    assign work_go    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W-$bits(t_result)){1'b0}}, r_out};

    // data bit count, clamped to 5..8
    always_comb begin
        if (r_cfg_bits < DATA_BITS_MIN) begin
            frame_bits = DATA_BITS_MIN;
        end else if (r_cfg_bits > DATA_BITS_MAX) begin
            frame_bits = DATA_BITS_MAX;
        end else begin
            frame_bits = r_cfg_bits;
        end
    end

    assign tx_cnt_inc = r_tx_cnt + 4'd1;
    assign rx_cnt_inc = r_rx_cnt + 4'd1;
    assign tx_bit     = r_tx_shift[r_tx_cnt[2:0]];

    // transmitter
    always_comb begin
        n_tx_phase = r_tx_phase;
        n_tx_shift = r_tx_shift;
        n_tx_cnt   = r_tx_cnt;
        n_tx_par   = r_tx_par;
        n_tx_line  = r_tx_line;
        load_drop  = 1'b0;
        if (r_in_kind == KIND_LOAD) begin
            if (r_tx_phase != TXP_IDLE) begin
                load_drop = 1'b1;
            end else begin
                n_tx_shift = r_in_byte;
                n_tx_cnt   = 4'd0;
                n_tx_par   = 1'b0;
                n_tx_phase = TXP_START;
            end
        end else begin
            unique case (r_tx_phase)
                TXP_IDLE: begin
                end
                TXP_START: begin
                    n_tx_line  = 1'b0;
                    n_tx_cnt   = 4'd0;
                    n_tx_par   = 1'b0;
                    n_tx_phase = TXP_DATA;
                end
                TXP_DATA: begin
                    n_tx_line = tx_bit;
                    n_tx_par  = r_tx_par ^ tx_bit;
                    n_tx_cnt  = tx_cnt_inc;
                    if (tx_cnt_inc >= frame_bits) begin
                        n_tx_phase = r_cfg_par ? TXP_PARITY : TXP_STOP;
                    end
                end
                TXP_PARITY: begin
                    n_tx_line  = r_tx_par;
                    n_tx_phase = TXP_STOP;
                end
                TXP_STOP: begin
                    n_tx_line  = 1'b1;
                    n_tx_cnt   = 4'd0;
                    n_tx_par   = 1'b0;
                    n_tx_phase = TXP_GUARD;
                end
                default: begin
                    // guard period and unused codes
                    n_tx_line  = 1'b1;
                    n_tx_phase = TXP_IDLE;
                end
            endcase
        end
    end

    // receiver, advances on ticks only
    always_comb begin
        n_rx_phase = r_rx_phase;
        n_rx_shift = r_rx_shift;
        n_rx_cnt   = r_rx_cnt;
        n_rx_par   = r_rx_par;
        n_rx_flag  = r_rx_flag;
        rx_done    = 1'b0;
        rx_data    = 8'd0;
        rx_perr    = 1'b0;
        if (r_in_kind == KIND_TICK) begin
            unique case (r_rx_phase)
                RXP_IDLE: begin
                    if (!r_in_level) begin
                        n_rx_shift = 8'd0;
                        n_rx_cnt   = 4'd0;
                        n_rx_par   = 1'b0;
                        n_rx_flag  = 1'b0;
                        n_rx_phase = RXP_DATA;
                    end
                end
                RXP_DATA: begin
                    n_rx_shift = r_rx_shift | (8'(r_in_level) << r_rx_cnt[2:0]);
                    n_rx_par   = r_rx_par ^ r_in_level;
                    n_rx_cnt   = rx_cnt_inc;
                    if (rx_cnt_inc >= frame_bits) begin
                        n_rx_phase = r_cfg_par ? RXP_PARITY : RXP_STOP;
                    end
                end
                RXP_PARITY: begin
                    n_rx_flag  = r_in_level ^ r_rx_par;
                    n_rx_phase = RXP_STOP;
                end
                RXP_STOP: begin
                    n_rx_cnt   = 4'd0;
                    n_rx_par   = 1'b0;
                    n_rx_phase = RXP_GUARD;
                end
                RXP_GUARD: begin
                    rx_done    = 1'b1;
                    rx_data    = r_rx_shift;
                    rx_perr    = r_rx_flag;
                    n_rx_shift = 8'd0;
                    n_rx_flag  = 1'b0;
                    n_rx_phase = RXP_IDLE;
                end
                default: begin
                    n_rx_phase = RXP_IDLE;
                end
            endcase
        end
    end

    // result beat
    always_comb begin
        n_out.tx_level     = n_tx_line;
        n_out.tx_busy      = (n_tx_phase != TXP_IDLE);
        n_out.load_dropped = load_drop;
        n_out.rx_valid     = rx_done;
        n_out.rx_byte      = rx_data;
        n_out.parity_error = rx_perr;
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_bits <= DATA_BITS_MAX;
            r_cfg_par  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DATA_BITS: r_cfg_bits <= i_cfg_wdata;
                CFG_PARITY_EN: r_cfg_par  <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_kind  <= i_s_tuser;
            r_in_byte  <= i_s_tdata[7:0];
            r_in_level <= i_s_tdata[8];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (work_go) begin
            r_out <= n_out;
        end
    end

    // frame state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_phase <= TXP_IDLE;
            r_tx_shift <= 8'd0;
            r_tx_cnt   <= 4'd0;
            r_tx_par   <= 1'b0;
            r_tx_line  <= 1'b1;
            r_rx_phase <= RXP_IDLE;
            r_rx_shift <= 8'd0;
            r_rx_cnt   <= 4'd0;
            r_rx_par   <= 1'b0;
            r_rx_flag  <= 1'b0;
        end else if (work_go) begin
            r_tx_phase <= n_tx_phase;
            r_tx_shift <= n_tx_shift;
            r_tx_cnt   <= n_tx_cnt;
            r_tx_par   <= n_tx_par;
            r_tx_line  <= n_tx_line;
            r_rx_phase <= n_rx_phase;
            r_rx_shift <= n_rx_shift;
            r_rx_cnt   <= n_rx_cnt;
            r_rx_par   <= n_rx_par;
            r_rx_flag  <= n_rx_flag;
        end
    end

    // checks
    a_drop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.load_dropped) |-> r_out.tx_busy)
        else $error("load dropped while transmitter idle");

    a_idle_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tx_phase == TXP_IDLE) |-> r_tx_line)
        else $error("transmit line low while idle");

    a_perr_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.parity_error) |-> (r_out.rx_valid && !r_out.load_dropped))
        else $error("parity error without a received frame");

    a_rx_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rx_phase == RXP_IDLE) |-> (r_rx_shift == 8'd0 && !r_rx_flag))
        else $error("receiver idle with stale frame state");

    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !work_go |=> ($stable(r_tx_phase) && $stable(r_rx_phase)))
        else $error("frame state moved without a processed beat");

endmodule

/* test/tb_uart_frame_transceiver_top.sv */
// Self-checking testbench for the UART frame transceiver: framed line traffic, loads, config sweeps.
module tb_uart_frame_transceiver_top;
    import uft_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 160;
    localparam int HOLD_CYCLES = 100;

    // Tracks both serial state machines and holds the status beats still owed by the block
    class uart_status_model;
        logic [3:0] data_bits_reg;
        logic       parity_reg;
        logic [2:0] tx_phase;
        logic [7:0] tx_shift;
        logic [3:0] tx_count;
        logic       tx_parity;
        logic       tx_line;
        logic [2:0] rx_phase;
        logic [7:0] rx_shift;
        logic [3:0] rx_count;
        logic       rx_parity;
        logic       rx_flag;
        t_result    status_q[$];
        int         errors;
        int         checked;
        int         items;
        int         frames;
        int         drops;

        function new();
            data_bits_reg = DATA_BITS_MAX;
            parity_reg    = 1'b0;
            tx_phase      = TXP_IDLE;
            tx_shift      = '0;
            tx_count      = '0;
            tx_parity     = 1'b0;
            tx_line       = 1'b1;
            rx_phase      = RXP_IDLE;
            rx_shift      = '0;
            rx_count      = '0;
            rx_parity     = 1'b0;
            rx_flag       = 1'b0;
            errors        = 0;
            checked       = 0;
            items         = 0;
            frames        = 0;
            drops         = 0;
        endfunction

        function void write_reg(logic addr, logic [3:0] value);
            if (addr == CFG_DATA_BITS) begin
                data_bits_reg = value;
            end else begin
                parity_reg = value[0];
            end
        endfunction

        // Out-of-range data bit counts clamp to 5..8
        function logic [3:0] frame_len();
            if (data_bits_reg < DATA_BITS_MIN) return DATA_BITS_MIN;
            if (data_bits_reg > DATA_BITS_MAX) return DATA_BITS_MAX;
            return data_bits_reg;
        endfunction

        function t_result predict_status(logic kind, logic [7:0] data, logic level);
            t_result    r;
            logic       bit_v;
            logic [3:0] n;
            r = '0;
            n = frame_len();
            if (kind == KIND_LOAD) begin
                // load only touches the transmitter; dropped while a frame is running
                if (tx_phase != TXP_IDLE) begin
                    r.load_dropped = 1'b1;
                end else begin
                    tx_shift  = data;
                    tx_count  = '0;
                    tx_parity = 1'b0;
                    tx_phase  = TXP_START;
                end
            end else begin
                // transmitter advances one bit period
                case (tx_phase)
                    TXP_IDLE: ;
                    TXP_START: begin
                        tx_line   = 1'b0;
                        tx_count  = '0;
                        tx_parity = 1'b0;
                        tx_phase  = TXP_DATA;
                    end
                    TXP_DATA: begin
                        bit_v     = tx_shift[tx_count[2:0]];
                        tx_line   = bit_v;
                        tx_parity = tx_parity ^ bit_v;
                        tx_count  = tx_count + 4'd1;
                        if (tx_count >= n) tx_phase = parity_reg ? TXP_PARITY : TXP_STOP;
                    end
                    TXP_PARITY: begin
                        tx_line  = tx_parity;
                        tx_phase = TXP_STOP;
                    end
                    TXP_STOP: begin
                        tx_line   = 1'b1;
                        tx_count  = '0;
                        tx_parity = 1'b0;
                        tx_phase  = TXP_GUARD;
                    end
                    default: begin
                        tx_line  = 1'b1;
                        tx_phase = TXP_IDLE;
                    end
                endcase
                // receiver samples the line on the same tick
                case (rx_phase)
                    RXP_IDLE: begin
                        if (!level) begin
                            rx_shift  = '0;
                            rx_count  = '0;
                            rx_parity = 1'b0;
                            rx_flag   = 1'b0;
                            rx_phase  = RXP_DATA;
                        end
                    end
                    RXP_DATA: begin
                        rx_shift[rx_count[2:0]] = rx_shift[rx_count[2:0]] | level;
                        rx_parity = rx_parity ^ level;
                        rx_count  = rx_count + 4'd1;
                        if (rx_count >= n) rx_phase = parity_reg ? RXP_PARITY : RXP_STOP;
                    end
                    RXP_PARITY: begin
                        rx_flag  = level ^ rx_parity;
                        rx_phase = RXP_STOP;
                    end
                    RXP_STOP: begin
                        rx_count  = '0;
                        rx_parity = 1'b0;
                        rx_phase  = RXP_GUARD;
                    end
                    RXP_GUARD: begin
                        r.rx_valid     = 1'b1;
                        r.rx_byte      = rx_shift;
                        r.parity_error = rx_flag;
                        rx_shift       = '0;
                        rx_flag        = 1'b0;
                        rx_phase       = RXP_IDLE;
                    end
                    default: rx_phase = RXP_IDLE;
                endcase
            end
            r.tx_level = tx_line;
            r.tx_busy  = (tx_phase != TXP_IDLE);
            return r;
        endfunction

        // Note an accepted input beat
        function void take_item(logic kind, logic [IN_TDATA_W-1:0] tdata);
            t_result r;
            r = predict_status(kind, tdata[7:0], tdata[8]);
            status_q.push_back(r);
            items++;
            if (r.rx_valid) frames++;
            if (r.load_dropped) drops++;
        endfunction

        task report(string what, int got, int want);
            if (errors < 40) begin
                $display("mismatch at beat %0d: %s got %0h, expected %0h",
                         checked, what, got, want);
            end
            errors++;
        endtask

        // Check an accepted output beat against the oldest prediction
        task match_status(logic [OUT_TDATA_W-1:0] tdata);
            t_result got;
            t_result want;
            if (status_q.size() == 0) begin
                report("beat with nothing pending", 1, 0);
                return;
            end
            want = status_q.pop_front();
            got  = t_result'(tdata[$bits(t_result)-1:0]);
            if (got.tx_level !== want.tx_level)
                report("tx_level", int'(got.tx_level), int'(want.tx_level));
            if (got.tx_busy !== want.tx_busy)
                report("tx_busy", int'(got.tx_busy), int'(want.tx_busy));
            if (got.load_dropped !== want.load_dropped)
                report("load_dropped", int'(got.load_dropped), int'(want.load_dropped));
            if (got.rx_valid !== want.rx_valid)
                report("rx_valid", int'(got.rx_valid), int'(want.rx_valid));
            if (got.rx_byte !== want.rx_byte)
                report("rx_byte", int'(got.rx_byte), int'(want.rx_byte));
            if (got.parity_error !== want.parity_error)
                report("parity_error", int'(got.parity_error), int'(want.parity_error));
            if (tdata[OUT_TDATA_W-1:$bits(t_result)] !== '0)
                report("pad bits", int'(tdata[OUT_TDATA_W-1:$bits(t_result)]), 0);
            checked++;
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;    // [7:0] tx_byte, [8] rx_level
    logic                   i_s_tuser = 1'b0;  // [0] kind
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;         // [0] tx_level .. [12] parity_error
    logic                   i_cfg_we = 1'b0;
    logic                   i_cfg_addr = 1'b0;
    logic [3:0]             i_cfg_wdata = '0;

    uart_status_model sb = new();
    logic  line_q[$];     // receive line levels still to be sent on ticks
    int    cur_len = 8;
    logic  cur_par = 1'b0;
    logic  burst = 1'b0;  // no random gaps on either side while set
    int    cycles = 0;
    int    phases = 0;

    uart_frame_transceiver_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Beat monitor on both streams
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.take_item(i_s_tuser, i_s_tdata);
            if (o_m_tvalid && i_m_tready) sb.match_status(o_m_tdata);
        end
    end

    // Output side: random stalls, one long hold-off to back up the input
    initial begin : sink
        int  gap;
        bit  held;
        held = 1'b0;
        forever begin
            gap = burst ? 0 : $urandom_range(0, 4);
            if (!held && sb.checked >= 300) begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    task automatic send_item(logic kind, logic [7:0] data, logic level);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tuser  <= kind;
        i_s_tdata  <= IN_TDATA_W'({level, data});
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Both registers, written back to back once the pipeline has drained
    task automatic write_config(logic [3:0] nbits, logic par);
        logic [3:0] pword;
        pword = {3'($urandom_range(0, 7)), par};
        i_s_tvalid <= 1'b0;
        while (sb.status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_DATA_BITS;
        i_cfg_wdata <= nbits;
        @(posedge i_clk);
        sb.write_reg(CFG_DATA_BITS, nbits);
        i_cfg_addr  <= CFG_PARITY_EN;
        i_cfg_wdata <= pword;
        @(posedge i_clk);
        sb.write_reg(CFG_PARITY_EN, pword);
        i_cfg_we <= 1'b0;
        cur_len = int'((nbits < DATA_BITS_MIN) ? DATA_BITS_MIN :
                       (nbits > DATA_BITS_MAX) ? DATA_BITS_MAX : nbits);
        cur_par = par;
        phases++;
    endtask

    // Queue one line segment: mostly a well-formed frame, sometimes noise then resync highs
    function automatic void refill_line();
        logic [7:0] v;
        logic       par;
        burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) line_q.push_back(1'($urandom));
            repeat (13) line_q.push_back(1'b1);
        end else begin
            repeat ($urandom_range(0, 3)) line_q.push_back(1'b1);
            line_q.push_back(1'b0);
            v   = 8'($urandom);
            par = 1'b0;
            for (int i = 0; i < cur_len; i++) begin
                line_q.push_back(v[i]);
                par = par ^ v[i];
            end
            // parity mostly right, sometimes flipped
            if (cur_par) line_q.push_back(par ^ ($urandom_range(0, 4) == 0));
            // stop and guard levels are not checked by the receiver
            line_q.push_back($urandom_range(0, 7) != 0);
            line_q.push_back($urandom_range(0, 7) != 0);
        end
    endfunction

    // Ticks carry the queued line, loads are mixed in; ends with the receiver idle
    task automatic run_random(int target);
        int n;
        n = 0;
        while (n < target || line_q.size() != 0) begin
            if (line_q.size() == 0) refill_line();
            if ($urandom_range(0, 9) == 0) begin
                send_item(KIND_LOAD, 8'($urandom), 1'($urandom));
            end else begin
                send_item(KIND_TICK, 8'($urandom), line_q.pop_front());
            end
            n++;
        end
    endtask

    initial begin : stimulus
        logic [3:0] bits_set[8];
        logic       par_set[8];
        bits_set = '{4'd5, 4'd8, 4'd0, 4'd15, 4'd6, 4'd7, 4'd8, 4'd5};
        par_set  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed at reset config: all-ones byte out, second load dropped,
        // all-ones frame in, then all-zeros frame with a low stop level
        send_item(KIND_LOAD, 8'hFF, 1'b0);
        send_item(KIND_LOAD, 8'h00, 1'b1);
        line_q.push_back(1'b0);
        repeat (10) line_q.push_back(1'b1);
        repeat (10) line_q.push_back(1'b0);
        line_q.push_back(1'b1);
        while (line_q.size() != 0) send_item(KIND_TICK, 8'($urandom), line_q.pop_front());
        send_item(KIND_LOAD, 8'h00, 1'b0);

        // Random phases over several register settings
        for (int p = 0; p < 8; p++) begin
            write_config(bits_set[p], par_set[p]);
            run_random(PHASE_ITEMS);
        end
        i_s_tvalid <= 1'b0;

        // Drain, then allow a few cycles for stray beats
        while (sb.status_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d input beats across %0d register settings plus reset defaults",
                 sb.items, phases);
        $display("%0d frames received, %0d loads dropped, %0d status beats compared",
                 sb.frames, sb.drops, sb.checked);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
sv/uft_pkg.sv
sv/uart_frame_transceiver_top.sv
test/tb_uart_frame_transceiver_top.sv
